// ===== rtl/core/otmr_pkg.sv =====
// Shared types, codes and defaults of the one-shot timer table.
package otmr_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int TIME_W         = 32;
  localparam int HANDLE_W       = 16;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_CANCEL = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    KIND_ADDED     = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_FIRED     = 3'd2,
    KIND_CANCELLED = 3'd3,
    KIND_NOTFOUND  = 3'd4,
    KIND_TICKDONE  = 3'd5,
    KIND_CLEARED   = 3'd6
  } kind_t;

  // Outcome of the shared compare and subtract unit.
  typedef struct packed {
    logic              fire;
    logic [TIME_W-1:0] rest;
  } cmp_res_t;

endpackage

// ===== rtl/core/one_shot_timer_table.sv =====
// Top level of the one-shot timer table: slot walk sequencer, valid bits and result register.
//
// An input word is taken at a rising edge where start is high and busy is low; the
// in_ ports carry the operation (add, cancel, tick, clear) and its operands.
// Results leave on the out_ ports, each for one cycle under out_strobe; the receiver
// cannot hold them off. Every input word ends with exactly one result marked out_last.
// Add, cancel and tick walk the slots one per cycle: the slot memory gives one read a
// cycle and one compare and subtract unit serves all slots. A tick walks every slot;
// add and cancel stop at the first hit; clear walks no slot and goes straight to its
// result. Fired results of a tick come in ascending slot order, ahead of the tick done
// word. busy is high from the cycle after accept until the final result is shown, and
// the next word may be taken in that same cycle. Reset empties the table and zeroes
// the handle counter; the slot memories need no clearing since a slot's contents are
// used only while its valid bit is set.
module one_shot_timer_table #(
  parameter int NUM_TIMERS = otmr_pkg::NUM_TIMERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_func,
  input  logic [otmr_pkg::TIME_W-1:0]   in_duration,
  input  logic [otmr_pkg::HANDLE_W-1:0] in_target_handle,
  input  logic [otmr_pkg::TIME_W-1:0]   in_elapsed,
  output logic                          out_strobe,
  output logic [2:0]                    out_kind,
  output logic [otmr_pkg::HANDLE_W-1:0] out_handle,
  output logic                          out_last
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WALK   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  otmr_pkg::func_t func_r, func_nxt;
  logic [otmr_pkg::TIME_W-1:0]   dur_r, dur_nxt;
  logic [otmr_pkg::HANDLE_W-1:0] tgt_r, tgt_nxt;
  logic [otmr_pkg::TIME_W-1:0]   ela_r, ela_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          issue_r, issue_nxt;
  logic          p_vld_r, p_vld_nxt;
  logic [IW-1:0] p_idx_r, p_idx_nxt;
  logic [NUM_TIMERS-1:0] valid_r, valid_nxt;
  logic [otmr_pkg::HANDLE_W-1:0] hcnt_r, hcnt_nxt;
  otmr_pkg::kind_t res_kind_r, res_kind_nxt;
  logic [otmr_pkg::HANDLE_W-1:0] res_hdl_r, res_hdl_nxt;

  logic out_strobe_r, out_strobe_nxt;
  otmr_pkg::kind_t out_kind_r, out_kind_nxt;
  logic [otmr_pkg::HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic out_last_r, out_last_nxt;

  logic                          rd_en;
  logic [otmr_pkg::TIME_W-1:0]   rd_rem;
  logic [otmr_pkg::HANDLE_W-1:0] rd_hdl;
  logic                          wr_rem_en, wr_hdl_en;
  logic [otmr_pkg::TIME_W-1:0]   wr_rem;
  logic [otmr_pkg::HANDLE_W-1:0] new_hdl;
  otmr_pkg::cmp_res_t            cmp;

  otmr_store #(
    .NUM_TIMERS (NUM_TIMERS),
    .IW         (IW)
  ) u_store (
    .clk       (clk),
    .rd_en     (rd_en),
    .rd_addr   (idx_r),
    .rd_rem    (rd_rem),
    .rd_hdl    (rd_hdl),
    .wr_rem_en (wr_rem_en),
    .wr_hdl_en (wr_hdl_en),
    .wr_addr   (p_idx_r),
    .wr_rem    (wr_rem),
    .wr_hdl    (new_hdl)
  );

  otmr_alu u_alu (
    .remaining (rd_rem),
    .elapsed   (ela_r),
    .res       (cmp)
  );

  // The handle counter skips zero when it wraps.
  assign new_hdl = (hcnt_r == '1) ? otmr_pkg::HANDLE_W'(1) : hcnt_r + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    dur_nxt        = dur_r;
    tgt_nxt        = tgt_r;
    ela_nxt        = ela_r;
    idx_nxt        = idx_r;
    issue_nxt      = issue_r;
    p_vld_nxt      = p_vld_r;
    p_idx_nxt      = p_idx_r;
    valid_nxt      = valid_r;
    hcnt_nxt       = hcnt_r;
    res_kind_nxt   = res_kind_r;
    res_hdl_nxt    = res_hdl_r;
    out_strobe_nxt = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_handle_nxt = out_handle_r;
    out_last_nxt   = out_last_r;
    rd_en          = 1'b0;
    wr_rem_en      = 1'b0;
    wr_hdl_en      = 1'b0;
    wr_rem         = cmp.rest;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt    = otmr_pkg::func_t'(in_func);
          dur_nxt     = in_duration;
          tgt_nxt     = in_target_handle;
          ela_nxt     = in_elapsed;
          idx_nxt     = '0;
          issue_nxt   = 1'b1;
          p_vld_nxt   = 1'b0;
          res_hdl_nxt = '0;
          state_nxt   = S_WALK;
          unique case (otmr_pkg::func_t'(in_func))
            otmr_pkg::FUNC_ADD:    res_kind_nxt = otmr_pkg::KIND_FULL;
            otmr_pkg::FUNC_CANCEL: res_kind_nxt = otmr_pkg::KIND_NOTFOUND;
            otmr_pkg::FUNC_TICK:   res_kind_nxt = otmr_pkg::KIND_TICKDONE;
            otmr_pkg::FUNC_CLEAR: begin
              res_kind_nxt = otmr_pkg::KIND_CLEARED;
              state_nxt    = S_FINISH;
            end
            default: res_kind_nxt = otmr_pkg::KIND_CLEARED;
          endcase
        end
      end

      S_WALK: begin
        // Read side: one slot address a cycle into the memory.
        if (issue_r) begin
          rd_en     = 1'b1;
          p_vld_nxt = 1'b1;
          p_idx_nxt = idx_r;
          if (idx_r == LAST_IDX) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          p_vld_nxt = 1'b0;
        end

        // Process side: the slot read in the previous cycle.
        if (p_vld_r) begin
          if (p_idx_r == LAST_IDX) begin
            state_nxt = S_FINISH;
          end
          case (func_r)
            otmr_pkg::FUNC_ADD: begin
              if (!valid_r[p_idx_r]) begin
                valid_nxt[p_idx_r] = 1'b1;
                wr_rem_en          = 1'b1;
                wr_hdl_en          = 1'b1;
                wr_rem             = dur_r;
                hcnt_nxt           = new_hdl;
                res_kind_nxt       = otmr_pkg::KIND_ADDED;
                res_hdl_nxt        = new_hdl;
                issue_nxt          = 1'b0;
                p_vld_nxt          = 1'b0;
                state_nxt          = S_FINISH;
              end
            end
            otmr_pkg::FUNC_CANCEL: begin
              if (valid_r[p_idx_r] && (rd_hdl == tgt_r)) begin
                valid_nxt[p_idx_r] = 1'b0;
                res_kind_nxt       = otmr_pkg::KIND_CANCELLED;
                res_hdl_nxt        = tgt_r;
                issue_nxt          = 1'b0;
                p_vld_nxt          = 1'b0;
                state_nxt          = S_FINISH;
              end
            end
            otmr_pkg::FUNC_TICK: begin
              if (valid_r[p_idx_r]) begin
                if (cmp.fire) begin
                  valid_nxt[p_idx_r] = 1'b0;
                  out_strobe_nxt     = 1'b1;
                  out_kind_nxt       = otmr_pkg::KIND_FIRED;
                  out_handle_nxt     = rd_hdl;
                  out_last_nxt       = 1'b0;
                end else begin
                  wr_rem_en = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end

      S_FINISH: begin
        if (func_r == otmr_pkg::FUNC_CLEAR) begin
          valid_nxt = '0;
        end
        out_strobe_nxt = 1'b1;
        out_kind_nxt   = res_kind_r;
        out_handle_nxt = res_hdl_r;
        out_last_nxt   = 1'b1;
        state_nxt      = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      issue_r      <= 1'b0;
      p_vld_r      <= 1'b0;
      valid_r      <= '0;
      hcnt_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issue_r      <= issue_nxt;
      p_vld_r      <= p_vld_nxt;
      valid_r      <= valid_nxt;
      hcnt_r       <= hcnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    dur_r        <= dur_nxt;
    tgt_r        <= tgt_nxt;
    ela_r        <= ela_nxt;
    idx_r        <= idx_nxt;
    p_idx_r      <= p_idx_nxt;
    res_kind_r   <= res_kind_nxt;
    res_hdl_r    <= res_hdl_nxt;
    out_kind_r   <= out_kind_nxt;
    out_handle_r <= out_handle_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_kind   = out_kind_r;
  assign out_handle = out_handle_r;
  assign out_last   = out_last_r;

endmodule

// ===== rtl/core/otmr_alu.sv =====
// Shared compare and subtract unit: remaining time against elapsed time.
module otmr_alu (
  input  logic [otmr_pkg::TIME_W-1:0] remaining,
  input  logic [otmr_pkg::TIME_W-1:0] elapsed,
  output otmr_pkg::cmp_res_t          res
);

  logic [otmr_pkg::TIME_W:0] diff;

  // The borrow bit says remaining is below elapsed; a zero difference means equal.
  assign diff     = {1'b0, remaining} - {1'b0, elapsed};
  assign res.fire = diff[otmr_pkg::TIME_W] || (diff[otmr_pkg::TIME_W-1:0] == '0);
  assign res.rest = diff[otmr_pkg::TIME_W-1:0];

endmodule

// ===== rtl/core/otmr_store.sv =====
// Slot memories for remaining time and handle, one write and one registered read a cycle.
module otmr_store #(
  parameter int NUM_TIMERS = otmr_pkg::NUM_TIMERS_DEF,
  parameter int IW         = 4
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [IW-1:0]                 rd_addr,
  output logic [otmr_pkg::TIME_W-1:0]   rd_rem,
  output logic [otmr_pkg::HANDLE_W-1:0] rd_hdl,
  input  logic                          wr_rem_en,
  input  logic                          wr_hdl_en,
  input  logic [IW-1:0]                 wr_addr,
  input  logic [otmr_pkg::TIME_W-1:0]   wr_rem,
  input  logic [otmr_pkg::HANDLE_W-1:0] wr_hdl
);

  logic [otmr_pkg::TIME_W-1:0]   rem_mem [NUM_TIMERS];
  logic [otmr_pkg::HANDLE_W-1:0] hdl_mem [NUM_TIMERS];

  always_ff @(posedge clk) begin
    if (wr_rem_en) begin
      rem_mem[wr_addr] <= wr_rem;
    end
    if (wr_hdl_en) begin
      hdl_mem[wr_addr] <= wr_hdl;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_rem <= rem_mem[rd_addr];
      rd_hdl <= hdl_mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/otmr_chk.sv =====
// Port-level checker for the one-shot timer table and its bind to the top level.
module otmr_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_strobe,
  input logic [2:0]                    out_kind,
  input logic [otmr_pkg::HANDLE_W-1:0] out_handle,
  input logic                          out_last
);

  // Every accepted word keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after accepting a word");

  // The final word of an item is shown once the block has gone idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |-> !busy)
    else $error("final result shown while still busy");

  // Only fired results come ahead of the final word, and only while the block is busy.
  a_mid_fired: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |-> busy && (out_kind == otmr_pkg::KIND_FIRED))
    else $error("unexpected intermediate result");

  // A fired timer always carries a nonzero handle.
  a_fired_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_kind == otmr_pkg::KIND_FIRED) |-> (out_handle != '0))
    else $error("fired result with zero handle");

  // Leaving busy always comes with the final word of the item.
  a_fall_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_strobe && out_last)
    else $error("item ended without a final result");

endmodule

bind one_shot_timer_table otmr_chk u_otmr_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_kind   (out_kind),
  .out_handle (out_handle),
  .out_last   (out_last)
);
